@@ src/assert_macros.svh @@
// Assertion helpers shared by the union-find RTL.
// Every check samples on the rising edge of its clock and is held off while
// its active-low reset is low; the usual form uses clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset
`define DSU_ASSERT_ON(label, clk_s, rst_n_s, prop, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (prop)) else $error(msg);

// Usual form inside the block: clk and arst_n
`define DSU_ASSERT(label, prop, msg) \
	`DSU_ASSERT_ON(label, clk, arst_n, prop, msg)

`endif

@@ src/dsu_pkg.sv @@
// ----------------------------------------------------------------------------
// dsu_pkg: union-find engine shared definitions
// Sizes, opcodes, beat types and memory port bundles for the disjoint-set core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dsu_pkg;

	// Node count and field widths
	localparam int NODES     = 1024;
	localparam int NODE_W    = 10;
	localparam int CNT_W     = 11;
	// Only node indexes that fit the 10-bit field can ever be stored
	localparam int MEM_DEPTH = (NODES > (1 << NODE_W)) ? (1 << NODE_W) : NODES;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	localparam logic [NODE_W:0] NODE_LIMIT = MEM_DEPTH[NODE_W:0];
	localparam addr_t           LAST_ADDR  = addr_t'(MEM_DEPTH - 1);
	localparam cnt_t            COUNT_ONE  = cnt_t'(1);
	localparam cnt_t            COUNT_MAX  = '1;

	// Request opcodes
	localparam logic [1:0] OP_FIND  = 2'd0;
	localparam logic [1:0] OP_UNION = 2'd1;
	localparam logic [1:0] OP_MAKE  = 2'd2;

	typedef struct packed {
		logic [1:0] opcode;
		node_t      node_a;
		node_t      node_b;
	} req_beat_t;

	typedef struct packed {
		node_t root_a;
		node_t root_b;
		logic  already_joined;
		node_t merged_root;
	} rsp_beat_t;

	// Parent-link memory port bundle
	typedef struct packed {
		logic  we;
		addr_t waddr;
		node_t wdata;
		logic  re;
		addr_t raddr;
	} par_port_t;

	// Set-size memory port bundle
	typedef struct packed {
		logic  we;
		addr_t waddr;
		cnt_t  wdata;
		logic  re;
		addr_t raddr;
	} cnt_port_t;

	// Node has a memory entry
	function automatic logic node_stored(node_t n);
		return {1'b0, n} < NODE_LIMIT;
	endfunction

	function automatic addr_t to_addr(node_t n);
		return n[ADDR_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ src/dsu_ram.sv @@
// ----------------------------------------------------------------------------
// dsu_ram: single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle; a read of the entry written
// in the same cycle returns the new data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsu_ram #(
	parameter int WIDTH  = 10,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read with write forwarding
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= (we && (waddr == raddr)) ? wdata : mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ src/dsu_ctrl.sv @@
// ----------------------------------------------------------------------------
// dsu_ctrl: union-find request sequencer
// Clears both memories after reset, then walks parent chains, compresses
// paths and links roots by size, one request at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dsu_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire dsu_pkg::req_beat_t  req,
	output logic                     res_valid,
	input  wire logic                res_ready,
	output dsu_pkg::rsp_beat_t       res,
	output dsu_pkg::par_port_t       par,
	input  wire dsu_pkg::node_t      par_rdata,
	output dsu_pkg::cnt_port_t       cnt,
	input  wire dsu_pkg::cnt_t       cnt_rdata
);

	import dsu_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_COMP,
		ST_FIN,
		ST_CNT_A,
		ST_CNT_B,
		ST_RESP
	} state_t;

	state_t     state_q, state_d;
	logic       phase_b_q, phase_b_d;
	logic [1:0] op_q, op_d;
	node_t      b_q, b_d;
	node_t      cur_q, cur_d;
	node_t      start_q, start_d;
	node_t      root_q, root_d;
	node_t      ra_q, ra_d;
	node_t      rb_q, rb_d;
	cnt_t       cnt_a_q, cnt_a_d;
	addr_t      clr_q, clr_d;
	rsp_beat_t  res_q, res_d;

	// link decision
	logic        a_smaller;
	node_t       big_n, small_n;
	logic [CNT_W:0] sum_w;
	cnt_t        sum_sat;

	assign a_smaller = cnt_a_q < cnt_rdata;
	assign big_n     = a_smaller ? rb_q : ra_q;
	assign small_n   = a_smaller ? ra_q : rb_q;
	assign sum_w     = {1'b0, cnt_a_q} + {1'b0, cnt_rdata};
	assign sum_sat   = sum_w[CNT_W] ? COUNT_MAX : sum_w[CNT_W-1:0];

	// next-state and memory commands
	always_comb begin
		state_d   = state_q;
		phase_b_d = phase_b_q;
		op_d      = op_q;
		b_d       = b_q;
		cur_d     = cur_q;
		start_d   = start_q;
		root_d    = root_q;
		ra_d      = ra_q;
		rb_d      = rb_q;
		cnt_a_d   = cnt_a_q;
		clr_d     = clr_q;
		res_d     = res_q;
		par       = '0;
		cnt       = '0;
		req_stall = 1'b1;
		res_valid = 1'b0;

		case (state_q)
			// reset pass: every node its own singleton
			ST_CLEAR: begin
				par.we    = 1'b1;
				par.waddr = clr_q;
				par.wdata = node_t'(clr_q);
				cnt.we    = 1'b1;
				cnt.waddr = clr_q;
				cnt.wdata = COUNT_ONE;
				clr_d     = clr_q + addr_t'(1);
				if (clr_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end

			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					op_d      = req.opcode;
					b_d       = req.node_b;
					phase_b_d = 1'b0;
					cur_d     = req.node_a;
					start_d   = req.node_a;
					case (req.opcode)
						OP_FIND, OP_UNION: begin
							if (node_stored(req.node_a)) begin
								par.re    = 1'b1;
								par.raddr = to_addr(req.node_a);
								state_d   = ST_WALK;
							end else begin
								root_d  = req.node_a;
								state_d = ST_FIN;
							end
						end
						OP_MAKE: begin
							if (node_stored(req.node_a)) begin
								par.we    = 1'b1;
								par.waddr = to_addr(req.node_a);
								par.wdata = req.node_a;
								cnt.we    = 1'b1;
								cnt.waddr = to_addr(req.node_a);
								cnt.wdata = COUNT_ONE;
							end
							res_d = '{root_a: req.node_a, root_b: req.node_a,
								already_joined: 1'b1, merged_root: req.node_a};
							state_d = ST_RESP;
						end
						default: begin
							// unused opcode: no state change, all-zero result
							res_d   = '0;
							state_d = ST_RESP;
						end
					endcase
				end
			end

			// follow parent links up to the root
			ST_WALK: begin
				if ((par_rdata == cur_q) || !node_stored(par_rdata)) begin
					root_d = cur_q;
					if (start_q == cur_q) begin
						state_d = ST_FIN;
					end else begin
						cur_d     = start_q;
						par.re    = 1'b1;
						par.raddr = to_addr(start_q);
						state_d   = ST_COMP;
					end
				end else begin
					cur_d     = par_rdata;
					par.re    = 1'b1;
					par.raddr = to_addr(par_rdata);
				end
			end

			// second walk: point each node on the path at the root
			ST_COMP: begin
				par.we    = 1'b1;
				par.waddr = to_addr(cur_q);
				par.wdata = root_q;
				if (!node_stored(par_rdata) || (par_rdata == root_q)) begin
					state_d = ST_FIN;
				end else begin
					cur_d     = par_rdata;
					par.re    = 1'b1;
					par.raddr = to_addr(par_rdata);
				end
			end

			// one root found
			ST_FIN: begin
				if (!phase_b_q) begin
					ra_d = root_q;
					if (op_q == OP_UNION) begin
						phase_b_d = 1'b1;
						cur_d     = b_q;
						start_d   = b_q;
						if (node_stored(b_q)) begin
							par.re    = 1'b1;
							par.raddr = to_addr(b_q);
							state_d   = ST_WALK;
						end else begin
							root_d = b_q;
						end
					end else begin
						res_d = '{root_a: root_q, root_b: root_q,
							already_joined: 1'b1, merged_root: root_q};
						state_d = ST_RESP;
					end
				end else begin
					rb_d = root_q;
					if (ra_q == root_q) begin
						res_d = '{root_a: ra_q, root_b: root_q,
							already_joined: 1'b1, merged_root: ra_q};
						state_d = ST_RESP;
					end else if (!node_stored(ra_q) || !node_stored(root_q)) begin
						res_d = '{root_a: ra_q, root_b: root_q,
							already_joined: 1'b0, merged_root: ra_q};
						state_d = ST_RESP;
					end else begin
						cnt.re    = 1'b1;
						cnt.raddr = to_addr(ra_q);
						state_d   = ST_CNT_A;
					end
				end
			end

			ST_CNT_A: begin
				cnt_a_d   = cnt_rdata;
				cnt.re    = 1'b1;
				cnt.raddr = to_addr(rb_q);
				state_d   = ST_CNT_B;
			end

			// hang smaller root under larger, add sizes
			ST_CNT_B: begin
				par.we    = 1'b1;
				par.waddr = to_addr(small_n);
				par.wdata = big_n;
				cnt.we    = 1'b1;
				cnt.waddr = to_addr(big_n);
				cnt.wdata = sum_sat;
				res_d = '{root_a: ra_q, root_b: rb_q,
					already_joined: 1'b0, merged_root: big_n};
				state_d = ST_RESP;
			end

			ST_RESP: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state, clear pointer and phase flag, reset asynchronously
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			phase_b_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			clr_q     <= clr_d;
			phase_b_q <= phase_b_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		op_q    <= op_d;
		b_q     <= b_d;
		cur_q   <= cur_d;
		start_q <= start_d;
		root_q  <= root_d;
		ra_q    <= ra_d;
		rb_q    <= rb_d;
		cnt_a_q <= cnt_a_d;
		res_q   <= res_d;
	end

	assign res = res_q;

	// checks
	`DSU_ASSERT(a_find_consistent, (res_valid && (op_q == OP_FIND)) |-> (res.already_joined && (res.root_a == res.root_b) && (res.root_b == res.merged_root)), "find result roots disagree")
	`DSU_ASSERT(a_merge_from_roots, (res_valid && !res.already_joined) |-> ((res.merged_root == res.root_a) || (res.merged_root == res.root_b)), "merged root is neither input root")
	`DSU_ASSERT(a_link_no_self, (state_q == ST_CNT_B) |-> (par.we && (par.wdata != small_n) && (ra_q != rb_q)), "union links a root to itself")

endmodule

`default_nettype wire

@@ src/disjoint_set_union_find_core.sv @@
// ----------------------------------------------------------------------------
// disjoint_set_union_find_core: union-find engine, union by size with
// path compression
// Request channel takes find, union and make beats; response channel returns
// both roots, the joined flag and the surviving root, one beat per request.
//
// Usage:
//  - req: valid/stall beat of {opcode, node_a, node_b}. rsp: valid/stall beat
//    of {root_a, root_b, already_joined, merged_root}.
//  - After reset a clearing pass over all MEM_DEPTH (1024) entries makes
//    every node a singleton; req_stall stays high until it ends.
//  - One request is in work at a time, and the parent memory gives one
//    read per cycle. A find walks node_a's links, then re-points each
//    walked node on a second pass; a union does the same for node_b and
//    reads both set sizes when the roots differ.
//  - The response sits in an output register; the next request is taken
//    while it waits. If rsp_stall holds, the following result waits in the
//    sequencer and req stalls until the register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module disjoint_set_union_find_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire dsu_pkg::req_beat_t req,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output dsu_pkg::rsp_beat_t      rsp
);

	import dsu_pkg::*;

	logic      res_valid;
	logic      res_ready;
	rsp_beat_t res;
	par_port_t par;
	cnt_port_t cnt;
	node_t     par_rdata;
	cnt_t      cnt_rdata;
	logic      rsp_valid_q;
	rsp_beat_t rsp_q;

	dsu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.par       (par),
		.par_rdata (par_rdata),
		.cnt       (cnt),
		.cnt_rdata (cnt_rdata)
	);

	// parent links
	dsu_ram #(
		.WIDTH  (NODE_W),
		.DEPTH  (MEM_DEPTH),
		.ADDR_W (ADDR_W)
	) u_par_ram (
		.clk   (clk),
		.we    (par.we),
		.waddr (par.waddr),
		.wdata (par.wdata),
		.re    (par.re),
		.raddr (par.raddr),
		.rdata (par_rdata)
	);

	// set sizes
	dsu_ram #(
		.WIDTH  (CNT_W),
		.DEPTH  (MEM_DEPTH),
		.ADDR_W (ADDR_W)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt.we),
		.waddr (cnt.waddr),
		.wdata (cnt.wdata),
		.re    (cnt.re),
		.raddr (cnt.raddr),
		.rdata (cnt_rdata)
	);

	// output register
	assign res_ready = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

@@ tb/tb_disjoint_set_union_find_core.sv @@
// ----------------------------------------------------------------------------
// tb_disjoint_set_union_find_core: self-checking bench for the union-find core
// Sends find, union, make and unused-opcode beats with random gaps and
// random response stalls. A shadow copy of the parent links and set sizes
// predicts every response; each beat is compared field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_disjoint_set_union_find_core;
	import dsu_pkg::*;

	localparam int SLOTS        = 1 << NODE_W;
	localparam int DIR_N        = 25;
	localparam int JOIN_N       = 100;
	localparam int RANDOM_ITEMS = 700;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 64;
	localparam int IDLE_LIMIT   = 20000;
	// Opcode the core does not decode
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		req_beat_t beat;
		logic      typed;
		rsp_beat_t want;
	} dir_row_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_beat_t req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_beat_t rsp;

	// Shadow of the core's parent links and set sizes
	node_t     link_q [SLOTS];
	cnt_t      size_q [SLOTS];
	rsp_beat_t pending_rsp [$];
	dir_row_t  dir_rows [DIR_N];

	int err_cnt     = 0;
	int idle_cycles = 0;
	int live_reqs   = 0;
	bit rush        = 1'b0;
	bit hold_rsp    = 1'b0;

	disjoint_set_union_find_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit has_slot(node_t n);
		return int'(n) < NODES;
	endfunction

	function automatic node_t any_node();
		return node_t'($urandom_range(0, SLOTS - 1));
	endfunction

	// Root lookup with path compression, as the core does it
	function automatic node_t root_compress(node_t n);
		node_t r;
		node_t cur;
		node_t nxt;
		int    steps;
		if (!has_slot(n))
			return n;
		r = n;
		steps = 0;
		while (link_q[r] != r && steps < NODES) begin
			if (!has_slot(link_q[r]))
				break;
			r = link_q[r];
			steps++;
		end
		cur = n;
		steps = 0;
		while (cur != r && steps < NODES) begin
			nxt = link_q[cur];
			link_q[cur] = r;
			if (!has_slot(nxt))
				break;
			cur = nxt;
			steps++;
		end
		return r;
	endfunction

	// Expected response of one request; updates the shadow
	function automatic rsp_beat_t predict_rsp(req_beat_t b);
		rsp_beat_t o;
		node_t     big_r;
		node_t     lesser_r;
		int        sum;
		o = '0;
		case (b.opcode)
			OP_FIND: begin
				o.root_a         = root_compress(b.node_a);
				o.root_b         = o.root_a;
				o.already_joined = 1'b1;
				o.merged_root    = o.root_a;
			end
			OP_UNION: begin
				o.root_a = root_compress(b.node_a);
				o.root_b = root_compress(b.node_b);
				if (o.root_a == o.root_b) begin
					o.already_joined = 1'b1;
					o.merged_root    = o.root_a;
				end else if (!has_slot(o.root_a) || !has_slot(o.root_b)) begin
					o.merged_root = o.root_a;
				end else begin
					// smaller set hangs under the larger; tie keeps node_a's root
					big_r    = o.root_a;
					lesser_r = o.root_b;
					if (size_q[o.root_a] < size_q[o.root_b]) begin
						big_r    = o.root_b;
						lesser_r = o.root_a;
					end
					link_q[lesser_r] = big_r;
					sum = int'(size_q[big_r]) + int'(size_q[lesser_r]);
					size_q[big_r] = (sum > int'(COUNT_MAX)) ? COUNT_MAX : cnt_t'(sum);
					o.merged_root = big_r;
				end
			end
			OP_MAKE: begin
				if (has_slot(b.node_a)) begin
					link_q[b.node_a] = b.node_a;
					size_q[b.node_a] = COUNT_ONE;
				end
				o.root_a         = b.node_a;
				o.root_b         = b.node_a;
				o.already_joined = 1'b1;
				o.merged_root    = b.node_a;
			end
			default: begin
				o = '0;
			end
		endcase
		return o;
	endfunction

	function automatic req_beat_t mk_req(logic [1:0] op, node_t a, node_t b);
		req_beat_t r;
		r.opcode = op;
		r.node_a = a;
		r.node_b = b;
		return r;
	endfunction

	function automatic dir_row_t dir_entry(logic [1:0] op, int a, int b, logic typed,
			int ra, int rb, logic joined, int merged);
		dir_row_t e;
		e.beat                = mk_req(op, node_t'(a), node_t'(b));
		e.typed               = typed;
		e.want.root_a         = node_t'(ra);
		e.want.root_b         = node_t'(rb);
		e.want.already_joined = joined;
		e.want.merged_root    = node_t'(merged);
		return e;
	endfunction

	// Offer one request beat after a random gap; log its response once taken
	task automatic push_req(req_beat_t beat, bit typed, rsp_beat_t want);
		int        gap;
		rsp_beat_t got;
		gap = (rush || hold_rsp) ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			@(negedge clk) req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req       <= beat;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		got = predict_rsp(beat);
		pending_rsp = {pending_rsp, (typed ? want : got)};
		if (beat.opcode != OP_SPARE)
			live_reqs++;
	endtask

	task automatic quiet_req();
		@(negedge clk) req_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	// Compare one response beat with the oldest expectation
	task automatic check_rsp(rsp_beat_t seen);
		rsp_beat_t want;
		if (pending_rsp.size() == 0) begin
			$error("response beat with no request outstanding: root_a %0d merged_root %0d",
				seen.root_a, seen.merged_root);
			err_cnt++;
		end else begin
			want = pending_rsp.pop_front();
			if (seen.root_a !== want.root_a) begin
				$error("root_a: expected %0d, got %0d", want.root_a, seen.root_a);
				err_cnt++;
			end
			if (seen.root_b !== want.root_b) begin
				$error("root_b: expected %0d, got %0d", want.root_b, seen.root_b);
				err_cnt++;
			end
			if (seen.already_joined !== want.already_joined) begin
				$error("already_joined: expected %0d, got %0d",
					want.already_joined, seen.already_joined);
				err_cnt++;
			end
			if (seen.merged_root !== want.merged_root) begin
				$error("merged_root: expected %0d, got %0d", want.merged_root, seen.merged_root);
				err_cnt++;
			end
		end
	endtask

	// Response side: random stalls, one long hold-off on request
	initial begin : rsp_side
		int n;
		forever begin
			if (hold_rsp) begin
				@(negedge clk) rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_rsp = 1'b0;
			end else begin
				n = rush ? 0 : $urandom_range(0, 11);
				if (n > 0) begin
					@(negedge clk) rsp_stall <= 1'b1;
					repeat (n - 1) @(negedge clk);
				end
			end
			@(negedge clk) rsp_stall <= 1'b0;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
			check_rsp(rsp);
		end
	end

	// Watchdog: too long without any beat on either channel
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin : stim
		rsp_beat_t no_rsp;
		int        idx;
		int        base;
		int        pool_lo;
		int        pool_sz;
		int        len;
		int        remakes;
		int        roll;
		int        noise;
		node_t     pick_a;
		node_t     pick_b;
		bit        held;
		bit        drained;

		no_rsp = '0;
		for (idx = 0; idx < SLOTS; idx++) begin
			link_q[idx] = node_t'(idx);
			size_q[idx] = COUNT_ONE;
		end

		// Directed rows: op, node_a, node_b, typed, root_a, root_b, joined, merged
		dir_rows[0]  = dir_entry(OP_FIND,  0,    1023, 1'b1, 0,    0,    1'b1, 0);
		dir_rows[1]  = dir_entry(OP_FIND,  1023, 0,    1'b1, 1023, 1023, 1'b1, 1023);
		dir_rows[2]  = dir_entry(OP_UNION, 0,    1023, 1'b1, 0,    1023, 1'b0, 0);
		dir_rows[3]  = dir_entry(OP_UNION, 1023, 0,    1'b1, 0,    0,    1'b1, 0);
		dir_rows[4]  = dir_entry(OP_FIND,  1023, 0,    1'b1, 0,    0,    1'b1, 0);
		dir_rows[5]  = dir_entry(OP_MAKE,  1023, 682,  1'b1, 1023, 1023, 1'b1, 1023);
		dir_rows[6]  = dir_entry(OP_SPARE, 1023, 1023, 1'b1, 0,    0,    1'b0, 0);
		dir_rows[7]  = dir_entry(OP_SPARE, 0,    0,    1'b1, 0,    0,    1'b0, 0);
		dir_rows[8]  = dir_entry(OP_UNION, 5,    6,    1'b0, 0,    0,    1'b0, 0);
		dir_rows[9]  = dir_entry(OP_UNION, 7,    6,    1'b0, 0,    0,    1'b0, 0);
		dir_rows[10] = dir_entry(OP_UNION, 8,    9,    1'b0, 0,    0,    1'b0, 0);
		// two-level chain 9 -> 8 -> 5, then a find that compresses it
		dir_rows[11] = dir_entry(OP_UNION, 8,    5,    1'b0, 0,    0,    1'b0, 0);
		dir_rows[12] = dir_entry(OP_FIND,  9,    0,    1'b0, 0,    0,    1'b0, 0);
		// make on a root with members: they keep pointing at it
		dir_rows[13] = dir_entry(OP_MAKE,  5,    0,    1'b0, 0,    0,    1'b0, 0);
		dir_rows[14] = dir_entry(OP_FIND,  6,    0,    1'b0, 0,    0,    1'b0, 0);
		dir_rows[15] = dir_entry(OP_UNION, 10,   5,    1'b0, 0,    0,    1'b0, 0);
		dir_rows[16] = dir_entry(OP_FIND,  9,    0,    1'b0, 0,    0,    1'b0, 0);
		// make on a member: old root keeps its size
		dir_rows[17] = dir_entry(OP_MAKE,  6,    0,    1'b0, 0,    0,    1'b0, 0);
		dir_rows[18] = dir_entry(OP_UNION, 6,    9,    1'b0, 0,    0,    1'b0, 0);
		dir_rows[19] = dir_entry(OP_UNION, 682,  341,  1'b0, 0,    0,    1'b0, 0);
		dir_rows[20] = dir_entry(OP_FIND,  341,  0,    1'b0, 0,    0,    1'b0, 0);
		dir_rows[21] = dir_entry(OP_SPARE, 682,  341,  1'b1, 0,    0,    1'b0, 0);
		dir_rows[22] = dir_entry(OP_UNION, 1023, 1023, 1'b1, 1023, 1023, 1'b1, 1023);
		dir_rows[23] = dir_entry(OP_MAKE,  0,    1023, 1'b0, 0,    0,    1'b0, 0);
		dir_rows[24] = dir_entry(OP_FIND,  1023, 682,  1'b0, 0,    0,    1'b0, 0);

		// Reset; the core then clears its tables before taking requests
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		for (idx = 0; idx < DIR_N; idx++)
			push_req(dir_rows[idx].beat, dir_rows[idx].typed, dir_rows[idx].want);

		// Back-to-back run: join a stretch of nodes into node 0's set
		rush = 1'b1;
		for (idx = 0; idx < JOIN_N; idx++)
			push_req(mk_req(OP_UNION, '0, node_t'(idx)), 1'b0, no_rsp);
		rush = 1'b0;

		// Random part: mostly build-and-query sequences on a small node pool
		base    = live_reqs;
		held    = 1'b0;
		drained = 1'b0;
		while (live_reqs - base < RANDOM_ITEMS) begin
			if (!held && live_reqs - base >= RANDOM_ITEMS / 4) begin
				held     = 1'b1;
				hold_rsp = 1'b1;
			end
			if (!drained && live_reqs - base >= RANDOM_ITEMS / 2) begin
				drained = 1'b1;
				quiet_req();
				wait_drained();
			end
			rush = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) < 7) begin
				pool_sz = $urandom_range(2, 40);
				pool_lo = $urandom_range(0, SLOTS - pool_sz);
				remakes = $urandom_range(0, pool_sz);
				for (idx = 0; idx < remakes; idx++)
					push_req(mk_req(OP_MAKE, node_t'(pool_lo + idx), any_node()), 1'b0, no_rsp);
				len = $urandom_range(pool_sz, 2 * pool_sz);
				for (idx = 0; idx < len; idx++) begin
					pick_a = node_t'(pool_lo + $urandom_range(0, pool_sz - 1));
					pick_b = node_t'(pool_lo + $urandom_range(0, pool_sz - 1));
					roll   = $urandom_range(0, 99);
					if (roll < 55)
						push_req(mk_req(OP_UNION, pick_a, pick_b), 1'b0, no_rsp);
					else if (roll < 85)
						push_req(mk_req(OP_FIND, pick_a, any_node()), 1'b0, no_rsp);
					else if (roll < 95)
						push_req(mk_req(OP_MAKE, pick_a, any_node()), 1'b0, no_rsp);
					else
						push_req(mk_req(OP_SPARE, any_node(), any_node()), 1'b0, no_rsp);
				end
			end else begin
				// noise: any opcode, any nodes
				noise = $urandom_range(1, 8);
				for (idx = 0; idx < noise; idx++)
					push_req(mk_req(2'($urandom_range(0, 3)), any_node(), any_node()),
						1'b0, no_rsp);
			end
		end
		rush = 1'b0;

		quiet_req();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_rsp.size() != 0) begin
			$error("%0d responses never arrived", pending_rsp.size());
			err_cnt++;
		end
		if (err_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+src
src/dsu_pkg.sv
src/dsu_ram.sv
src/dsu_ctrl.sv
src/disjoint_set_union_find_core.sv
tb/tb_disjoint_set_union_find_core.sv
